### rtl/core/assert_macros.svh
// Assertion macros shared by the packet ring queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, disabled while reset is low.
`define PRQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the next clock edge.
`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/prq_pkg.sv
// Package with types, codes and defaults for the packet ring queue.
`default_nettype none

package prq_pkg;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ENTRY_BYTES_DEF = 128;

  // Field widths of the items
  localparam int KIND_W   = 3;
  localparam int LEN_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 7;
  localparam int STATUS_W = 2;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_READ  = 3'd2,
    KIND_POP   = 3'd3,
    KIND_DROP  = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_NO_ENTRY = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic exec;      // apply the item to the queue state
    logic len_read;  // fetch the length of the oldest entry
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic is_empty;
    logic is_full;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/prq_if.sv
// Valid/ready channel interfaces for items and results of the packet ring queue.
`default_nettype none

interface prq_in_if;
  logic                          valid;
  logic                          ready;
  logic [prq_pkg::KIND_W-1:0]    kind;
  logic [prq_pkg::LEN_W-1:0]     entry_length;
  logic [prq_pkg::BYTE_W-1:0]    data_byte;
  logic [prq_pkg::OFFSET_W-1:0]  byte_offset;

  modport source (output valid, output kind, output entry_length, output data_byte,
                  output byte_offset, input ready);
  modport sink (input valid, input kind, input entry_length, input data_byte,
                input byte_offset, output ready);
endinterface

interface prq_out_if;
  logic                          valid;
  logic                          ready;
  logic [prq_pkg::BYTE_W-1:0]    read_byte;
  logic [prq_pkg::LEN_W-1:0]     oldest_length;
  logic                          is_empty;
  logic                          is_full;
  logic [prq_pkg::BYTE_W-1:0]    checksum;
  logic [prq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output read_byte, output oldest_length, output is_empty,
                  output is_full, output checksum, output status, input ready);
  modport sink (input valid, input read_byte, input oldest_length, input is_empty,
                input is_full, input checksum, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/packet_ring_queue.sv
// Packet ring queue top level: controller, datapath and assertions.
//
// Usage: items arrive on in_i (valid/ready) and carry kind, entry_length,
// data_byte and byte_offset. Every accepted item yields exactly one result
// on out_o with read_byte, oldest_length, is_empty, is_full, checksum and
// status, taken after the item has updated the queue.
// The controller walks each item through capture, execute, length fetch and
// result load, and the length fetch is a registered read of the entry length
// memory. Only one item is in flight: a new item is not accepted until the
// previous one has been loaded into the result register.
// in_i.ready is high only while the controller is idle; the result register
// lets a new item enter while the previous result still waits on out_o.
// If the receiver stalls, the result register holds and the next item stops
// at its load step until the result is taken.
// Reset (rst_ni low) empties the ring, closes any open entry and clears the
// checksum; the entry memories are not cleared and need no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module packet_ring_queue #(
  parameter int QueueDepth = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int EntryBytes = prq_pkg::ENTRY_BYTES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  prq_in_if.sink     in_i,
  prq_out_if.source  out_o
);

  prq_pkg::ctrl_cmd_t  cmd;
  prq_pkg::dp_status_t dp_status;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  prq_dp #(
    .QueueDepth (QueueDepth),
    .EntryBytes (EntryBytes)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (in_i.kind),
    .entry_length_i  (in_i.entry_length),
    .data_byte_i     (in_i.data_byte),
    .byte_offset_i   (in_i.byte_offset),
    .read_byte_o     (out_o.read_byte),
    .oldest_length_o (out_o.oldest_length),
    .is_empty_o      (out_o.is_empty),
    .is_full_o       (out_o.is_full),
    .checksum_o      (out_o.checksum),
    .status_o        (out_o.status),
    .dp_status_o     (dp_status)
  );

  // Full and empty never hold together
  `PRQ_ASSERT(a_full_not_empty, clk_i, rst_ni,
              !(dp_status.is_full && dp_status.is_empty),
              "ring reports full and empty at once")

  // One item in flight: no accept on the cycle after an accept
  `PRQ_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready,
                   "item accepted while another is in flight")

  // A fresh result is raised only for an accepted item
  `PRQ_ASSERT(a_result_latency, clk_i, rst_ni,
              !$rose(out_o.valid) || $past(in_i.valid && in_i.ready, 4),
              "result raised without a matching item")

endmodule

`default_nettype wire

### rtl/core/prq_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`default_nettype none

module prq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output prq_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LEN,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load_free;

  // Result register is free when empty or being taken this cycle
  assign load_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode commands from the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.len_read = (state_q == S_LEN);
    cmd_o.load_out = (state_q == S_OUT) && load_free;
  end

  // Hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
          if (out_ready_i) out_valid_q <= 1'b0;
        end
        S_EXEC: begin
          state_q <= S_LEN;
          if (out_ready_i) out_valid_q <= 1'b0;
        end
        S_LEN: begin
          state_q <= S_OUT;
          if (out_ready_i) out_valid_q <= 1'b0;
        end
        S_OUT: begin
          if (load_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/prq_dp.sv
// Datapath: ring indices, entry memories, checksum and the result register.
`default_nettype none

module prq_dp #(
  parameter int QueueDepth = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int EntryBytes = prq_pkg::ENTRY_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire prq_pkg::ctrl_cmd_t                cmd_i,
  input  wire logic [prq_pkg::KIND_W-1:0]        kind_i,
  input  wire logic [prq_pkg::LEN_W-1:0]         entry_length_i,
  input  wire logic [prq_pkg::BYTE_W-1:0]        data_byte_i,
  input  wire logic [prq_pkg::OFFSET_W-1:0]      byte_offset_i,
  output logic [prq_pkg::BYTE_W-1:0]             read_byte_o,
  output logic [prq_pkg::LEN_W-1:0]              oldest_length_o,
  output logic                                   is_empty_o,
  output logic                                   is_full_o,
  output logic [prq_pkg::BYTE_W-1:0]             checksum_o,
  output logic [prq_pkg::STATUS_W-1:0]           status_o,
  output prq_pkg::dp_status_t                    dp_status_o
);

  localparam int IdxW      = $clog2(QueueDepth);
  localparam int ByteDepth = QueueDepth * EntryBytes;
  localparam int AddrW     = $clog2(ByteDepth);
  localparam int LenW      = prq_pkg::LEN_W;
  localparam int ByteW     = prq_pkg::BYTE_W;

  localparam logic [IdxW-1:0] LastSlot = IdxW'(QueueDepth - 1);
  localparam logic [LenW-1:0] MaxLen   = LenW'(EntryBytes);

  // Captured item
  logic [prq_pkg::KIND_W-1:0]   kind_q;
  logic [LenW-1:0]              len_q;
  logic [ByteW-1:0]             byte_q;
  logic [prq_pkg::OFFSET_W-1:0] off_q;

  // Queue state
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic            full_q, full_d;
  logic [LenW-1:0] wcount_q, wcount_d;
  logic [LenW-1:0] exp_len_q, exp_len_d;
  logic            open_q, open_d;
  logic [ByteW-1:0] csum_q, csum_d;

  // Per-item results
  prq_pkg::status_e status_q, status_d;
  logic             rd_hit_q, rd_hit_d;

  // Memories and their registered read data
  logic [ByteW-1:0] bytes_mem [ByteDepth];
  logic [LenW-1:0]  len_mem [QueueDepth];
  logic [ByteW-1:0] rd_data_q;
  logic [LenW-1:0]  oldest_len_q;

  // Memory controls
  logic             byte_we;
  logic             byte_re;
  logic             len_we;
  logic [LenW-1:0]  sat_len;
  logic [LenW-1:0]  wcount_inc;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic             empty_now;
  logic [IdxW-1:0]  head_next;
  logic [IdxW-1:0]  head_prev;
  logic [IdxW-1:0]  tail_next;

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      len_q  <= entry_length_i;
      byte_q <= data_byte_i;
      off_q  <= byte_offset_i;
    end
  end

  assign empty_now  = !full_q && (head_q == tail_q);
  assign head_next  = (head_q == LastSlot) ? '0 : head_q + 1'b1;
  assign head_prev  = (head_q == '0) ? LastSlot : head_q - 1'b1;
  assign tail_next  = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
  assign sat_len    = (len_q > MaxLen) ? MaxLen : len_q;
  assign wcount_inc = wcount_q + 1'b1;
  assign wr_addr    = AddrW'(AddrW'(head_q) * AddrW'(EntryBytes)) + AddrW'(wcount_q);
  assign rd_addr    = AddrW'(AddrW'(tail_q) * AddrW'(EntryBytes)) + AddrW'(off_q);

  // Apply the item to the queue state
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    full_d    = full_q;
    wcount_d  = wcount_q;
    exp_len_d = exp_len_q;
    open_d    = open_q;
    csum_d    = csum_q;
    status_d  = prq_pkg::STATUS_OK;
    rd_hit_d  = 1'b0;
    byte_we   = 1'b0;
    byte_re   = 1'b0;
    len_we    = 1'b0;
    case (kind_q)
      prq_pkg::KIND_START: begin
        if (full_q) begin
          status_d = prq_pkg::STATUS_FULL;
        end else begin
          len_we    = 1'b1;
          exp_len_d = sat_len;
          wcount_d  = '0;
          open_d    = 1'b1;
          // Commit an empty entry at once
          if (sat_len == '0) begin
            head_d = head_next;
            full_d = (head_next == tail_q);
            open_d = 1'b0;
          end
        end
      end
      prq_pkg::KIND_DATA: begin
        if (!open_q || wcount_q >= exp_len_q || wcount_q >= MaxLen) begin
          status_d = prq_pkg::STATUS_NO_ENTRY;
        end else begin
          byte_we  = 1'b1;
          csum_d   = csum_q + byte_q;
          wcount_d = wcount_inc;
          // Commit when the last byte lands
          if (wcount_inc >= exp_len_q) begin
            head_d = head_next;
            full_d = (head_next == tail_q);
            open_d = 1'b0;
          end
        end
      end
      prq_pkg::KIND_READ: begin
        if (empty_now) begin
          status_d = prq_pkg::STATUS_EMPTY;
        end else begin
          rd_hit_d = (LenW'(off_q) < oldest_len_q) && (LenW'(off_q) < MaxLen);
          byte_re  = rd_hit_d;
        end
      end
      prq_pkg::KIND_POP: begin
        if (empty_now) begin
          status_d = prq_pkg::STATUS_EMPTY;
        end else begin
          tail_d = tail_next;
          full_d = 1'b0;
        end
      end
      prq_pkg::KIND_DROP: begin
        // Abandon any open entry, then remove the newest committed one
        open_d    = 1'b0;
        wcount_d  = '0;
        exp_len_d = '0;
        if (empty_now) begin
          status_d = prq_pkg::STATUS_EMPTY;
        end else begin
          head_d = head_prev;
          full_d = 1'b0;
        end
      end
      prq_pkg::KIND_CLEAR: begin
        csum_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Hold queue state, advance on execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      full_q    <= 1'b0;
      wcount_q  <= '0;
      exp_len_q <= '0;
      open_q    <= 1'b0;
      csum_q    <= '0;
    end else if (cmd_i.exec) begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      full_q    <= full_d;
      wcount_q  <= wcount_d;
      exp_len_q <= exp_len_d;
      open_q    <= open_d;
      csum_q    <= csum_d;
    end
  end

  // Per-item status
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  // Byte memory write
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && byte_we) begin
      bytes_mem[wr_addr] <= byte_q;
    end
  end

  // Byte memory read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && byte_re) begin
      rd_data_q <= bytes_mem[rd_addr];
    end
  end

  // Length memory write at the open slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && len_we) begin
      len_mem[head_q] <= sat_len;
    end
  end

  // Length memory read at the oldest slot, after the update
  always_ff @(posedge clk_i) begin
    if (cmd_i.len_read) begin
      oldest_len_q <= len_mem[tail_q];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_byte_o     <= rd_hit_q ? rd_data_q : '0;
      oldest_length_o <= empty_now ? '0 : oldest_len_q;
      is_empty_o      <= empty_now;
      is_full_o       <= full_q;
      checksum_o      <= csum_q;
      status_o        <= status_q;
    end
  end

  assign dp_status_o.is_empty = empty_now;
  assign dp_status_o.is_full  = full_q;

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the packet ring queue: directed table, random packets, predictor check.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = prq_pkg::QUEUE_DEPTH_DEF;
  localparam int ENTRY = prq_pkg::ENTRY_BYTES_DEF;

  // Kinds past the last defined one; the block must treat them as no-ops
  localparam logic [prq_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [prq_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [prq_pkg::KIND_W-1:0]   kind;
    logic [prq_pkg::LEN_W-1:0]    len;
    logic [prq_pkg::BYTE_W-1:0]   dbyte;
    logic [prq_pkg::OFFSET_W-1:0] offset;
  } item_t;

  typedef struct packed {
    logic [prq_pkg::BYTE_W-1:0]   read_byte;
    logic [prq_pkg::LEN_W-1:0]    oldest_length;
    logic                         is_empty;
    logic                         is_full;
    logic [prq_pkg::BYTE_W-1:0]   checksum;
    logic [prq_pkg::STATUS_W-1:0] status;
  } result_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  prq_in_if  in_ch ();
  prq_out_if out_ch ();

  packet_ring_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Ring shadow state
  int          ring_head;
  int          ring_tail;
  bit          ring_full;
  logic [7:0]  slot_len [DEPTH];
  logic [7:0]  slot_data [DEPTH][ENTRY];
  int          fill_count;
  int          fill_target;
  bit          fill_open;
  logic [7:0]  byte_sum;

  result_t     due_reports [$];
  row_t        plan [$];
  int          fault_count;
  int          sent_items;
  int          quiet_left [2];

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit ring_is_empty();
    return !ring_full && ring_head == ring_tail;
  endfunction

  function automatic int fill_level();
    return ring_full ? DEPTH : (ring_head - ring_tail + DEPTH) % DEPTH;
  endfunction

  // Advance the head past the entry being written
  function automatic void commit_slot();
    ring_head = (ring_head + 1) % DEPTH;
    if (ring_head == ring_tail) ring_full = 1'b1;
    fill_open = 1'b0;
  endfunction

  // Apply one item to the shadow ring and return the report it should produce
  function automatic result_t apply_to_ring(item_t it);
    result_t r;
    int      ln;
    r = '0;
    r.status = prq_pkg::STATUS_OK;
    case (it.kind)
      prq_pkg::KIND_START: begin
        if (ring_full) begin
          r.status = prq_pkg::STATUS_FULL;
        end else begin
          ln = (it.len > ENTRY) ? ENTRY : it.len;
          slot_len[ring_head] = 8'(ln);
          fill_target = ln;
          fill_count = 0;
          fill_open = 1'b1;
          if (ln == 0) commit_slot();
        end
      end
      prq_pkg::KIND_DATA: begin
        if (!fill_open || fill_count >= fill_target || fill_count >= ENTRY) begin
          r.status = prq_pkg::STATUS_NO_ENTRY;
        end else begin
          slot_data[ring_head][fill_count] = it.dbyte;
          byte_sum = byte_sum + it.dbyte;
          fill_count++;
          if (fill_count >= fill_target) commit_slot();
        end
      end
      prq_pkg::KIND_READ: begin
        if (ring_is_empty()) r.status = prq_pkg::STATUS_EMPTY;
        else if (it.offset < slot_len[ring_tail]) r.read_byte = slot_data[ring_tail][it.offset];
      end
      prq_pkg::KIND_POP: begin
        if (ring_is_empty()) begin
          r.status = prq_pkg::STATUS_EMPTY;
        end else begin
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_full = 1'b0;
        end
      end
      prq_pkg::KIND_DROP: begin
        fill_open = 1'b0;
        fill_count = 0;
        fill_target = 0;
        if (ring_is_empty()) begin
          r.status = prq_pkg::STATUS_EMPTY;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_full = 1'b0;
        end
      end
      prq_pkg::KIND_CLEAR: byte_sum = '0;
      default: ;
    endcase
    r.oldest_length = ring_is_empty() ? 8'd0 : slot_len[ring_tail];
    r.is_empty = ring_is_empty();
    r.is_full = ring_full;
    r.checksum = byte_sum;
    return r;
  endfunction

  // Draw a random wait, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left[side] = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic void plan_row(logic [prq_pkg::KIND_W-1:0] k, int l, int b, int o,
                                   bit typed = 1'b0, result_t res = '0);
    row_t row;
    row.it.kind = k;
    row.it.len = 8'(l);
    row.it.dbyte = 8'(b);
    row.it.offset = 7'(o);
    row.typed = typed;
    row.res = res;
    plan.push_back(row);
  endfunction

  // Compare one report with the oldest one due
  function automatic void check_report(result_t got);
    result_t want;
    if (due_reports.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: unexpected report rd=%02h len=%0d empty=%0b full=%0b sum=%02h st=%0d",
                 $realtime, got.read_byte, got.oldest_length, got.is_empty, got.is_full,
                 got.checksum, got.status);
      return;
    end
    want = due_reports.pop_front();
    if (got.read_byte !== want.read_byte || got.oldest_length !== want.oldest_length ||
        got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
        got.checksum !== want.checksum || got.status !== want.status) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: mismatch exp rd=%02h len=%0d empty=%0b full=%0b sum=%02h st=%0d",
                 $realtime, want.read_byte, want.oldest_length, want.is_empty, want.is_full,
                 want.checksum, want.status,
                 " | got rd=%02h len=%0d empty=%0b full=%0b sum=%02h st=%0d",
                 got.read_byte, got.oldest_length, got.is_empty, got.is_full,
                 got.checksum, got.status);
    end
  endfunction

  // Offer one item, hold it until accepted, then record the report it should give
  task automatic send_item(logic [prq_pkg::KIND_W-1:0] k, int l, int b, int o,
                           bit typed = 1'b0, result_t typed_res = '0);
    int      gap;
    item_t   it;
    result_t predicted;
    it.kind = k;
    it.len = 8'(l);
    it.dbyte = 8'(b);
    it.offset = 7'(o);
    gap = draw_wait(0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= it.kind;
    in_ch.entry_length <= it.len;
    in_ch.data_byte    <= it.dbyte;
    in_ch.byte_offset  <= it.offset;
    @(posedge clk_i);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk_i);
    predicted = apply_to_ring(it);
    due_reports.push_back(typed ? typed_res : predicted);
    sent_items++;
  endtask

  // Hold the sender until every outstanding report is in
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (due_reports.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall at random, check every report taken
  initial begin
    int      stall;
    result_t got;
    out_ch.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait(1);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_ch.valid === 1'b1 && out_ch.ready)) @(posedge clk_i);
      got.read_byte     = out_ch.read_byte;
      got.oldest_length = out_ch.oldest_length;
      got.is_empty      = out_ch.is_empty;
      got.is_full       = out_ch.is_full;
      got.checksum      = out_ch.checksum;
      got.status        = out_ch.status;
      check_report(got);
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int r;
    int plen;
    int nbytes;
    int cut;
    int off;
    int big_left;
    int next_pause;

    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.entry_length = '0;
    in_ch.data_byte = '0;
    in_ch.byte_offset = '0;
    rst_ni = 1'b0;
    ring_head = 0;
    ring_tail = 0;
    ring_full = 1'b0;
    fill_count = 0;
    fill_target = 0;
    fill_open = 1'b0;
    byte_sum = '0;
    fault_count = 0;
    sent_items = 0;
    quiet_left[0] = 0;
    quiet_left[1] = 0;
    foreach (slot_len[i]) slot_len[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: empty-ring errors, stray byte, saturation, abandon, reads, clear, drop, spare kinds, full
    plan_row(prq_pkg::KIND_READ, 0, 0, 0, 1'b1,
             '{8'h00, 8'd0, 1'b1, 1'b0, 8'h00, prq_pkg::STATUS_EMPTY});
    plan_row(prq_pkg::KIND_POP, 255, 255, 127, 1'b1,
             '{8'h00, 8'd0, 1'b1, 1'b0, 8'h00, prq_pkg::STATUS_EMPTY});
    plan_row(prq_pkg::KIND_DROP, 0, 0, 0, 1'b1,
             '{8'h00, 8'd0, 1'b1, 1'b0, 8'h00, prq_pkg::STATUS_EMPTY});
    plan_row(prq_pkg::KIND_DATA, 0, 8'hFF, 0, 1'b1,
             '{8'h00, 8'd0, 1'b1, 1'b0, 8'h00, prq_pkg::STATUS_NO_ENTRY});
    plan_row(prq_pkg::KIND_START, 255, 0, 0);
    plan_row(prq_pkg::KIND_START, 2, 0, 0);
    plan_row(prq_pkg::KIND_DATA, 0, 8'hFF, 0);
    plan_row(prq_pkg::KIND_DATA, 0, 8'h00, 0);
    plan_row(prq_pkg::KIND_READ, 0, 0, 0);
    plan_row(prq_pkg::KIND_READ, 0, 0, 1);
    plan_row(prq_pkg::KIND_READ, 0, 0, 127);
    plan_row(prq_pkg::KIND_CLEAR, 0, 0, 0);
    plan_row(prq_pkg::KIND_START, 1, 0, 0);
    plan_row(prq_pkg::KIND_DATA, 0, 8'h80, 0);
    plan_row(prq_pkg::KIND_START, 3, 0, 0);
    plan_row(prq_pkg::KIND_DATA, 0, 8'h01, 0);
    plan_row(prq_pkg::KIND_DROP, 0, 0, 0);
    plan_row(KIND_SPARE_6, 0, 0, 0);
    plan_row(KIND_SPARE_7, 255, 255, 127);
    for (int i = 0; i < DEPTH - 1; i++) plan_row(prq_pkg::KIND_START, 0, 0, 0);
    plan_row(prq_pkg::KIND_START, 0, 0, 0, 1'b1,
             '{8'h00, 8'd2, 1'b0, 1'b1, 8'h81, prq_pkg::STATUS_FULL});

    foreach (plan[i])
      send_item(plan[i].it.kind, plan[i].it.len, plan[i].it.dbyte, plan[i].it.offset,
                plan[i].typed, plan[i].res);
    wait_drained();

    // Random part: mostly whole packets, reads and pops, some noise and broken packets
    big_left = 3;
    next_pause = 120;
    while (sent_items < 450) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if (ring_full && $urandom_range(0, 3) != 0)
          send_item(prq_pkg::KIND_POP, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 80) begin
          plen = $urandom_range(0, 6);
        end else if (r < 94 || big_left == 0) begin
          plen = $urandom_range(7, 24);
        end else begin
          big_left--;
          plen = $urandom_range(0, 1) ? ENTRY : $urandom_range(ENTRY + 1, 255);
        end
        send_item(prq_pkg::KIND_START, plen, $urandom_range(0, 255), $urandom_range(0, 127));
        nbytes = (plen > ENTRY) ? ENTRY : plen;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nbytes) : -1;
        for (int i = 0; i < nbytes && i != cut; i++)
          send_item(prq_pkg::KIND_DATA, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 127));
        // Break the packet: abandon it with a new start or drop it
        if (cut >= 0)
          send_item($urandom_range(0, 1) ? prq_pkg::KIND_DROP : prq_pkg::KIND_START,
                    $urandom_range(0, 6), $urandom_range(0, 255), $urandom_range(0, 127));
      end else if (r < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          // Empty the ring and pop once more
          repeat (fill_level() + 1)
            send_item(prq_pkg::KIND_POP, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 127));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            if (!ring_is_empty() && slot_len[ring_tail] != 0 && $urandom_range(0, 3) != 0)
              off = $urandom_range(0, slot_len[ring_tail] - 1);
            else
              off = $urandom_range(0, 127);
            send_item(prq_pkg::KIND_READ, $urandom_range(0, 255), $urandom_range(0, 255), off);
          end
          if ($urandom_range(0, DEPTH) < fill_level() + 1)
            send_item(prq_pkg::KIND_POP, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 127));
        end
      end else begin
        send_item(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 127));
      end
      if (sent_items >= next_pause) begin
        wait_drained();
        next_pause += 120;
      end
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
